[hdl/grid_ray_caster_unit_assert.svh]
// Assertion macros used by the checker of the ray caster.
`ifndef GRID_RAY_CASTER_UNIT_ASSERT_SVH
`define GRID_RAY_CASTER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define GRU_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define GRU_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/gcr_pkg.sv]
`timescale 1ns / 1ps
package gcr_pkg;

  localparam int GCR_MAP_SIDE = 64;
  localparam int GCR_PADDR_W  = 4;
  localparam int GCR_RECIP_W  = 25;
  localparam int GCR_ACC_W    = 34;
  localparam int GCR_COORD_W  = 11;

  localparam logic [1:0] REG_MAP_WIDTH  = 2'd0;
  localparam logic [1:0] REG_MAP_HEIGHT = 2'd1;
  localparam logic [1:0] REG_STEP_LIMIT = 2'd2;

  localparam logic [6:0] MAP_WIDTH_RST  = 7'd64;
  localparam logic [6:0] MAP_HEIGHT_RST = 7'd64;
  localparam logic [7:0] STEP_LIMIT_RST = 8'd100;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RECIP,
    ST_MULT,
    ST_WALK,
    ST_DONE
  } gcr_state_t;

  typedef struct packed {
    logic        start;
    logic [15:0] divisor;
  } gcr_div_req_t;

endpackage

[hdl/grid_ray_caster_unit.sv]
`timescale 1ns / 1ps
// Grid ray caster. A beat with op = 0 writes one 4-bit map cell in its accept
// cycle and gives no result. A beat with op = 1 casts a ray and gives one result
// beat. Items are handled one at a time: a cast walks N grid crossings (at most
// step_limit, or one if step_limit is zero) after a setup by the shared-nothing
// pair of bit-serial reciprocal dividers (x and y in parallel) plus a multiply
// step for the first crossings; the walk then takes one crossing per cycle, the
// map read of one crossing overlapping the next crossing's arithmetic. A
// finished result sits in an output register, so the next item is taken while
// it waits. No clearing pass runs after reset: cells never written read as
// undefined.
module grid_ray_caster_unit import gcr_pkg::*; #(
  parameter int MAP_SIDE = GCR_MAP_SIDE
) (
  input  logic                   clk,
  input  logic                   rst,
  // APB-style configuration port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [GCR_PADDR_W-1:0] paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  // input beats
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   op,
  input  logic [5:0]             cell_col,
  input  logic [5:0]             cell_row,
  input  logic [3:0]             cell_value,
  input  logic [15:0]            start_x,
  input  logic [15:0]            start_y,
  input  logic signed [15:0]     dir_x,
  input  logic signed [15:0]     dir_y,
  // result beats
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [23:0]            distance,
  output logic [3:0]             wall_value,
  output logic                   crossed_horizontal
);

  localparam int DEPTH = MAP_SIDE * MAP_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [GCR_COORD_W-1:0] SIDE_C = GCR_COORD_W'(MAP_SIDE);

  // configuration registers
  logic [6:0] map_width;
  logic [6:0] map_height;
  logic [7:0] step_limit;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width  <= MAP_WIDTH_RST;
      map_height <= MAP_HEIGHT_RST;
      step_limit <= STEP_LIMIT_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_MAP_WIDTH:  map_width  <= pwdata[6:0];
        REG_MAP_HEIGHT: map_height <= pwdata[6:0];
        REG_STEP_LIMIT: step_limit <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MAP_WIDTH:  prdata = {25'd0, map_width};
      REG_MAP_HEIGHT: prdata = {25'd0, map_height};
      REG_STEP_LIMIT: prdata = {24'd0, step_limit};
      default:        prdata = '0;
    endcase
  end

  // control
  gcr_state_t state, state_next;
  logic       in_acc, cast_acc;
  logic       div_done;

  assign in_ready = (state == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign cast_acc = in_acc && (op == OP_CAST);

  // ray setup
  logic [15:0] mag_x, mag_y;
  gcr_div_req_t req_x, req_y;
  logic [GCR_RECIP_W-1:0] recip_x, recip_y;
  logic        done_y;

  assign mag_x = dir_x[15] ? 16'(-dir_x) : dir_x;
  assign mag_y = dir_y[15] ? 16'(-dir_y) : dir_y;
  assign req_x = '{start: cast_acc, divisor: mag_x};
  assign req_y = '{start: cast_acc, divisor: mag_y};

  gcr_recip u_recip_x (.clk(clk), .rst(rst), .req(req_x), .done(div_done), .quot(recip_x));
  gcr_recip u_recip_y (.clk(clk), .rst(rst), .req(req_y), .done(done_y), .quot(recip_y));

  logic [9:0] frac_x, frac_y;
  logic       neg_x, neg_y, act_x, act_y;
  logic [10:0] span_x, span_y;
  logic [35:0] prod_x, prod_y;

  assign span_x = neg_x ? {1'b0, frac_x} : (11'd1024 - {1'b0, frac_x});
  assign span_y = neg_y ? {1'b0, frac_y} : (11'd1024 - {1'b0, frac_y});
  assign prod_x = 36'(span_x) * 36'(recip_x);
  assign prod_y = 36'(span_y) * 36'(recip_y);

  // walk state
  logic signed [GCR_COORD_W-1:0] bx, by, nbx, nby;
  logic [GCR_ACC_W-1:0] tv, th, ntravel;
  logic [8:0]  steps, steps_new;
  logic        step_y, oob_n, last_n;
  logic        pend, p_oob, p_last, p_horiz;
  logic [GCR_ACC_W-1:0] p_travel;
  logic        stop;
  logic [GCR_COORD_W-1:0] wlim, hlim;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [3:0]  rd_data;
  logic        wr_en;

  // clamp the in-use map size to the physical side
  assign wlim = (GCR_COORD_W'(map_width) > SIDE_C) ? SIDE_C : GCR_COORD_W'(map_width);
  assign hlim = (GCR_COORD_W'(map_height) > SIDE_C) ? SIDE_C : GCR_COORD_W'(map_height);

  always_comb begin
    // ties step the vertical line
    step_y    = act_y && (!act_x || (th < tv));
    nbx       = step_y ? bx : (neg_x ? bx - 11'sd1 : bx + 11'sd1);
    nby       = step_y ? (neg_y ? by - 11'sd1 : by + 11'sd1) : by;
    ntravel   = step_y ? th : tv;
    steps_new = steps + 9'd1;
    oob_n     = nbx[GCR_COORD_W-1] || nby[GCR_COORD_W-1] ||
                ($unsigned(nbx) >= wlim) || ($unsigned(nby) >= hlim);
    // a zero limit still takes one crossing
    last_n    = steps_new >= {1'b0, step_limit};
    stop      = pend && (p_oob || (rd_data != 4'd0) || p_last);
  end

  // read the cell of the crossing being taken; data returns next cycle
  assign rd_addr = AW'(32'($unsigned(nby)) * 32'(MAP_SIDE) + 32'($unsigned(nbx)));
  assign wr_addr = AW'(32'(cell_row) * 32'(MAP_SIDE) + 32'(cell_col));
  assign wr_en   = in_acc && (op == OP_WRITE) &&
                   (9'(cell_col) < 9'(MAP_SIDE)) && (9'(cell_row) < 9'(MAP_SIDE));

  gcr_map_ram #(.DEPTH(DEPTH), .AW(AW)) u_map (
    .clk(clk), .we(wr_en), .waddr(wr_addr), .wdata(cell_value),
    .raddr(rd_addr), .rdata(rd_data)
  );

  // result holding
  logic [GCR_ACC_W-1:0] res_travel;
  logic [3:0]  res_val;
  logic        res_horiz;
  logic        out_free;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (cast_acc) state_next = ST_RECIP;
      ST_RECIP: if (div_done && done_y) state_next = ST_MULT;
      ST_MULT:  state_next = (act_x || act_y) ? ST_WALK : ST_DONE;
      ST_WALK:  if (stop) state_next = ST_DONE;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ray datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (cast_acc) begin
          frac_x <= start_x[9:0];
          frac_y <= start_y[9:0];
          neg_x  <= dir_x[15];
          neg_y  <= dir_y[15];
          act_x  <= (mag_x != 16'd0);
          act_y  <= (mag_y != 16'd0);
          bx     <= GCR_COORD_W'(start_x[15:10]);
          by     <= GCR_COORD_W'(start_y[15:10]);
        end
      end
      ST_MULT: begin
        tv         <= GCR_ACC_W'(prod_x[35:10]);
        th         <= GCR_ACC_W'(prod_y[35:10]);
        steps      <= '0;
        res_travel <= '0;
        res_val    <= 4'd0;
        res_horiz  <= 1'b0;
      end
      ST_WALK: begin
        if (stop) begin
          res_travel <= p_travel;
          res_val    <= p_oob ? 4'd0 : rd_data;
          res_horiz  <= p_horiz;
        end else begin
          // advance one crossing while the previous cell read lands
          bx       <= nbx;
          by       <= nby;
          steps    <= steps_new;
          p_travel <= ntravel;
          p_horiz  <= step_y;
          p_oob    <= oob_n;
          p_last   <= last_n;
          if (step_y) begin
            th <= th + GCR_ACC_W'(recip_y);
          end else begin
            tv <= tv + GCR_ACC_W'(recip_x);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (state == ST_MULT) begin
      pend <= 1'b0;
    end else if (state == ST_WALK) begin
      pend <= !stop;
    end
  end

  // output register: load when the slot is free, drop on the accepting beat
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      distance           <= (|res_travel[GCR_ACC_W-1:24]) ? 24'hFFFFFF : res_travel[23:0];
      wall_value         <= res_val;
      crossed_horizontal <= res_horiz;
    end
  end

endmodule

[hdl/gcr_recip.sv]
`timescale 1ns / 1ps
// Restoring divider: floor(2^24 / divisor), one quotient bit per cycle.
module gcr_recip import gcr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  gcr_div_req_t           req,
  output logic                   done,
  output logic [GCR_RECIP_W-1:0] quot
);

  logic [4:0]  cnt;
  logic        run;
  logic [16:0] rem;
  logic [15:0] divisor;
  logic [16:0] rem_sh;
  logic        ge;

  always_comb begin
    rem_sh = {rem[15:0], (cnt == 5'(GCR_RECIP_W - 1))};
    ge     = rem_sh >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= run && (cnt == 5'd0);
      if (req.start) begin
        run <= 1'b1;
        cnt <= 5'(GCR_RECIP_W - 1);
      end else if (run) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          run <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= '0;
      divisor <= req.divisor;
    end else if (run) begin
      rem  <= ge ? (rem_sh - {1'b0, divisor}) : rem_sh;
      quot <= {quot[GCR_RECIP_W-2:0], ge};
    end
  end

endmodule

[hdl/gcr_map_ram.sv]
`timescale 1ns / 1ps
// Tile map store: one write port, one read port, registered read data.
module gcr_map_ram import gcr_pkg::*; #(
  parameter int DEPTH = GCR_MAP_SIDE * GCR_MAP_SIDE,
  parameter int AW    = $clog2(GCR_MAP_SIDE * GCR_MAP_SIDE)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [3:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [3:0]    rdata
);

  logic [3:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[hdl/gcr_checker.sv]
`timescale 1ns / 1ps
`include "grid_ray_caster_unit_assert.svh"
// Port-level checks for the ray caster.
module gcr_checker import gcr_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        pready,
  input logic        in_valid,
  input logic        in_ready,
  input logic        op,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] distance
);

  `GRU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(distance), "result beat dropped or changed while stalled")
  `GRU_ASSERT_NEXT(a_cast_busy, in_valid && in_ready && op == OP_CAST, !in_ready, "new beat taken right after a cast")
  `GRU_ASSERT_NEXT(a_write_silent, in_valid && in_ready && op == OP_WRITE && !out_valid, !out_valid, "map write produced a result")
  `GRU_ASSERT_NOW(a_pready_high, 1'b1, pready, "pready went low")

endmodule

bind grid_ray_caster_unit gcr_checker u_gcr_checker (.*);
